// ===== hw/rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Widths, register indexes and shared constants for the rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int VEC_W    = 16;                 // vector component width
   localparam int QUAT_W   = 16;                 // quaternion register width
   localparam int PROD_W   = 2 * QUAT_W;         // quaternion component product
   localparam int NRM_W    = PROD_W + 1;         // squared length, unsigned
   localparam int MAT_W    = PROD_W + 2;         // rotation matrix entry, signed
   localparam int MV_W     = MAT_W + VEC_W;      // matrix entry times component
   localparam int SUM_W    = MV_W + 2;           // row sum, signed
   localparam int REM_W    = SUM_W + 1;          // rounded dividend, unsigned
   localparam int DIVR_W   = NRM_W + 1;          // divisor, twice the squared length
   localparam int QUO_W    = VEC_W + 2;          // quotient magnitude
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROT_W = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_X = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Y = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Z = 8'd3;

   localparam logic signed [QUAT_W-1:0] ROT_W_RESET = 16'sd16384;

   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [MAT_W-1:0]  mat_type;
   typedef logic signed [MV_W-1:0]   mv_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

endpackage

// ===== hw/rtl/quaternion_vector_rotation_top.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a stream of 3D vectors by a programmable quaternion.
// ----------------------------------------------------------------------------
// Usage:
// The rotation quaternion (w, x, y, z, each signed Q2.14) is written through
// the csr_ write channel at indexes 0 to 3; other indexes are ignored. Write
// it only while no transaction is in flight. Reset loads the identity (w = 1.0).
// Each req_ transaction carries one vector (x, y, z, signed 16 bit) and yields
// exactly one rsp_ transaction with the rotated vector and a clipped flag.
// The result is q * v * conj(q) / |q|^2, rounded to nearest (ties away from
// zero) and saturated; an all-zero quaternion gives a zero vector.
// The pipeline has five arithmetic stages (products, matrix, matrix times
// vector, row sums, rounding offset), an 18-stage divider that resolves one
// quotient bit per stage, and the output register. One transaction is
// accepted every cycle while the pipeline is not stalled. When the receiver
// holds rsp_tready low with a result waiting, the whole pipeline freezes and
// req_tready falls, so nothing is lost or repeated. Synchronous reset empties
// the pipeline.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_top
   import qvr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // vec_x, vec_y, vec_z
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // out_x, out_y, out_z
   output logic                  rsp_tuser,   // clipped
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [QUAT_W-1:0]     csr_data
);

   localparam logic signed [QUO_W:0] SAT_HI = (QUO_W+1)'(2**(VEC_W-1) - 1);
   localparam logic signed [QUO_W:0] SAT_LO = -(QUO_W+1)'(2**(VEC_W-1));

   // Configuration registers.
   logic signed [QUAT_W-1:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff <= ROT_W_RESET;
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         rot_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROT_W: rot_w_ff <= csr_data;
            CSR_ROT_X: rot_x_ff <= csr_data;
            CSR_ROT_Y: rot_y_ff <= csr_data;
            CSR_ROT_Z: rot_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves as one: it advances unless a result is held.
   logic adv;
   logic rsp_vld_ff;
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: the ten component products.
   logic     s1_vld_ff;
   vec_type  s1_v_ff [3];
   prod_type s1_ww_ff, s1_xx_ff, s1_yy_ff, s1_zz_ff;
   prod_type s1_xy_ff, s1_wz_ff, s1_xz_ff, s1_wy_ff, s1_yz_ff, s1_wx_ff;

   // Stage 2: rotation matrix and squared length.
   logic             s2_vld_ff;
   vec_type          s2_v_ff [3];
   mat_type          s2_m_ff [3][3];
   logic [NRM_W-1:0] s2_n_ff;

   // Stage 3: matrix entries times vector components.
   logic             s3_vld_ff;
   mv_type           s3_mv_ff [3][3];
   logic [NRM_W-1:0] s3_n_ff;

   // Stage 4: row sums.
   logic             s4_vld_ff;
   sum_type          s4_sum_ff [3];
   logic [NRM_W-1:0] s4_n_ff;

   // Stage 5: doubled magnitude plus half divisor, ready for the divider.
   logic              s5_vld_ff;
   logic [REM_W-1:0]  s5_rem_ff [3];
   logic              s5_neg_ff [3];
   logic [DIVR_W-1:0] s5_divr_ff;
   logic              s5_zero_ff;

   // Divider stages, one quotient bit per stage, most significant first.
   logic              dv_vld_ff  [QUO_W];
   logic [REM_W-1:0]  dv_rem_ff  [QUO_W][3];
   logic [QUO_W-1:0]  dv_quo_ff  [QUO_W][3];
   logic              dv_neg_ff  [QUO_W][3];
   logic [DIVR_W-1:0] dv_divr_ff [QUO_W];
   logic              dv_zero_ff [QUO_W];

   logic [REM_W-1:0]  dv_rem_in  [QUO_W][3];
   logic [QUO_W-1:0]  dv_quo_in  [QUO_W][3];

   // Output register.
   vec_type rsp_out_ff [3];
   logic    rsp_clip_ff;

   vec_type          req_v [3];
   mat_type          m_in [3][3];
   logic [NRM_W-1:0] n_in;

   assign req_v[0] = req_tdata[15:0];
   assign req_v[1] = req_tdata[31:16];
   assign req_v[2] = req_tdata[47:32];

   always_comb begin
      m_in[0][0] = MAT_W'(s1_ww_ff) + MAT_W'(s1_xx_ff) - MAT_W'(s1_yy_ff) - MAT_W'(s1_zz_ff);
      m_in[1][1] = MAT_W'(s1_ww_ff) - MAT_W'(s1_xx_ff) + MAT_W'(s1_yy_ff) - MAT_W'(s1_zz_ff);
      m_in[2][2] = MAT_W'(s1_ww_ff) - MAT_W'(s1_xx_ff) - MAT_W'(s1_yy_ff) + MAT_W'(s1_zz_ff);
      m_in[0][1] = (MAT_W'(s1_xy_ff) - MAT_W'(s1_wz_ff)) <<< 1;
      m_in[0][2] = (MAT_W'(s1_xz_ff) + MAT_W'(s1_wy_ff)) <<< 1;
      m_in[1][0] = (MAT_W'(s1_xy_ff) + MAT_W'(s1_wz_ff)) <<< 1;
      m_in[1][2] = (MAT_W'(s1_yz_ff) - MAT_W'(s1_wx_ff)) <<< 1;
      m_in[2][0] = (MAT_W'(s1_xz_ff) - MAT_W'(s1_wy_ff)) <<< 1;
      m_in[2][1] = (MAT_W'(s1_yz_ff) + MAT_W'(s1_wx_ff)) <<< 1;
      n_in = NRM_W'(unsigned'(s1_ww_ff)) + NRM_W'(unsigned'(s1_xx_ff))
           + NRM_W'(unsigned'(s1_yy_ff)) + NRM_W'(unsigned'(s1_zz_ff));
   end

   // Restoring division: each stage tries the divisor shifted to its bit.
   always_comb begin
      logic [REM_W-1:0] src_rem;
      logic [QUO_W-1:0] src_quo;
      logic [REM_W-1:0] trial;
      for (int k = 0; k < QUO_W; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               src_rem = s5_rem_ff[i];
               src_quo = '0;
               trial   = REM_W'(s5_divr_ff) << (QUO_W - 1);
            end else begin
               src_rem = dv_rem_ff[(k == 0) ? 0 : k - 1][i];
               src_quo = dv_quo_ff[(k == 0) ? 0 : k - 1][i];
               trial   = REM_W'(dv_divr_ff[(k == 0) ? 0 : k - 1]) << (QUO_W - 1 - k);
            end
            dv_rem_in[k][i] = src_rem;
            dv_quo_in[k][i] = src_quo;
            if (src_rem >= trial) begin
               dv_rem_in[k][i] = src_rem - trial;
               dv_quo_in[k][i][QUO_W-1-k] = 1'b1;
            end
         end
      end
   end

   // Sign restore and saturation for the output register.
   vec_type rsp_out_in [3];
   logic    rsp_clip_in;

   always_comb begin
      logic signed [QUO_W:0] sq;
      rsp_clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sq = signed'({1'b0, dv_quo_ff[QUO_W-1][i]});
         if (dv_neg_ff[QUO_W-1][i]) sq = -sq;
         if (dv_zero_ff[QUO_W-1]) begin
            rsp_out_in[i] = '0;
         end else if (sq > SAT_HI) begin
            rsp_out_in[i] = SAT_HI[VEC_W-1:0];
            rsp_clip_in   = 1'b1;
         end else if (sq < SAT_LO) begin
            rsp_out_in[i] = SAT_LO[VEC_W-1:0];
            rsp_clip_in   = 1'b1;
         end else begin
            rsp_out_in[i] = sq[VEC_W-1:0];
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k < QUO_W; k++) dv_vld_ff[k] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_tvalid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         dv_vld_ff[0] <= s5_vld_ff;
         for (int k = 1; k < QUO_W; k++) dv_vld_ff[k] <= dv_vld_ff[k-1];
         rsp_vld_ff   <= dv_vld_ff[QUO_W-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_v_ff  <= req_v;
         s1_ww_ff <= rot_w_ff * rot_w_ff;
         s1_xx_ff <= rot_x_ff * rot_x_ff;
         s1_yy_ff <= rot_y_ff * rot_y_ff;
         s1_zz_ff <= rot_z_ff * rot_z_ff;
         s1_xy_ff <= rot_x_ff * rot_y_ff;
         s1_wz_ff <= rot_w_ff * rot_z_ff;
         s1_xz_ff <= rot_x_ff * rot_z_ff;
         s1_wy_ff <= rot_w_ff * rot_y_ff;
         s1_yz_ff <= rot_y_ff * rot_z_ff;
         s1_wx_ff <= rot_w_ff * rot_x_ff;

         s2_v_ff <= s1_v_ff;
         s2_m_ff <= m_in;
         s2_n_ff <= n_in;

         s3_n_ff <= s2_n_ff;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               s3_mv_ff[i][j] <= MV_W'(s2_m_ff[i][j]) * MV_W'(s2_v_ff[j]);

         s4_n_ff <= s3_n_ff;
         for (int i = 0; i < 3; i++)
            s4_sum_ff[i] <= SUM_W'(s3_mv_ff[i][0]) + SUM_W'(s3_mv_ff[i][1])
                          + SUM_W'(s3_mv_ff[i][2]);

         // Round to nearest, ties away from zero: (2|S| + n) / 2n on magnitudes.
         s5_divr_ff <= {s4_n_ff, 1'b0};
         s5_zero_ff <= (s4_n_ff == '0);
         for (int i = 0; i < 3; i++) begin
            s5_neg_ff[i] <= s4_sum_ff[i][SUM_W-1];
            s5_rem_ff[i] <= {(s4_sum_ff[i][SUM_W-1] ? -s4_sum_ff[i] : s4_sum_ff[i]), 1'b0}
                          + REM_W'(s4_n_ff);
         end

         dv_divr_ff[0] <= s5_divr_ff;
         dv_zero_ff[0] <= s5_zero_ff;
         dv_neg_ff[0]  <= s5_neg_ff;
         for (int k = 1; k < QUO_W; k++) begin
            dv_divr_ff[k] <= dv_divr_ff[k-1];
            dv_zero_ff[k] <= dv_zero_ff[k-1];
            dv_neg_ff[k]  <= dv_neg_ff[k-1];
         end
         dv_rem_ff <= dv_rem_in;
         dv_quo_ff <= dv_quo_in;

         rsp_out_ff  <= rsp_out_in;
         rsp_clip_ff <= rsp_clip_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_out_ff[2], rsp_out_ff[1], rsp_out_ff[0]};
   assign rsp_tuser  = rsp_clip_ff;

endmodule
